// ----- rtl/core/range_pair_equal_count_core_defines.svh -----
// Assertion macros shared by the range pair equal count core.
`ifndef RANGE_PAIR_EQUAL_COUNT_CORE_DEFINES_SVH
`define RANGE_PAIR_EQUAL_COUNT_CORE_DEFINES_SVH

// Checks the consequent in the same cycle as the antecedent.
`define RPEC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define RPEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rpec_pkg.sv -----
// Types and constants of the range pair equal count core.
package rpec_pkg;

    localparam int MAX_LENGTH_DEFAULT  = 65536;
    localparam int VALUE_COUNT_DEFAULT = 65536;

    localparam int POS_W = 17;
    localparam int VAL_W = 16;
    localparam int SUM_W = 33;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STEP_FIRST_UP,
        STEP_SECOND_UP,
        STEP_FIRST_DOWN,
        STEP_SECOND_DOWN
    } step_kind_t;

    typedef struct packed {
        logic             op;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] element_value;
        logic [POS_W-1:0] first_left;
        logic [POS_W-1:0] first_right;
        logic [POS_W-1:0] second_left;
        logic [POS_W-1:0] second_right;
    } in_item_t;

    typedef struct packed {
        logic [SUM_W-1:0] pair_count;
        logic             is_answer;
    } out_item_t;

endpackage

// ----- rtl/core/rpec_ram.sv -----
// Single-port-write, single-port-read synchronous memory with registered read data.
module rpec_ram #(
    parameter int DEPTH = rpec_pkg::MAX_LENGTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = rpec_pkg::VAL_W
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/rpec_step.sv -----
// Histogram entry update and running sum update for one pointer step.
module rpec_step #(
    parameter int CNT_W = 17
) (
    input  rpec_pkg::step_kind_t        kind,
    input  logic [CNT_W-1:0]            first_count,
    input  logic [CNT_W-1:0]            second_count,
    input  logic [rpec_pkg::SUM_W-1:0]  sum,
    output logic [CNT_W-1:0]            first_count_new,
    output logic [CNT_W-1:0]            second_count_new,
    output logic [rpec_pkg::SUM_W-1:0]  sum_new
);

    logic [rpec_pkg::SUM_W-1:0] first_ext;
    logic [rpec_pkg::SUM_W-1:0] second_ext;

    assign first_ext  = rpec_pkg::SUM_W'(first_count);
    assign second_ext = rpec_pkg::SUM_W'(second_count);

    always_comb
    begin
        first_count_new  = first_count;
        second_count_new = second_count;
        sum_new          = sum;
        case (kind)
            rpec_pkg::STEP_FIRST_UP:
            begin
                sum_new         = sum + second_ext;
                first_count_new = first_count + CNT_W'(1);
            end
            rpec_pkg::STEP_SECOND_UP:
            begin
                sum_new          = sum + first_ext;
                second_count_new = second_count + CNT_W'(1);
            end
            rpec_pkg::STEP_FIRST_DOWN:
            begin
                sum_new = sum - second_ext;
                if (first_count != '0)
                begin
                    first_count_new = first_count - CNT_W'(1);
                end
            end
            rpec_pkg::STEP_SECOND_DOWN:
            begin
                sum_new = sum - first_ext;
                if (second_count != '0)
                begin
                    second_count_new = second_count - CNT_W'(1);
                end
            end
            default:
            begin
                sum_new = sum;
            end
        endcase
    end

endmodule

// ----- rtl/core/range_pair_equal_count_core.sv -----
// Range pair equal count core: top level with the step sequencer and both memories.
//
// Load transactions write array elements into the element memory until the first
// query arrives; each passes through the done state. A query counts equal-value
// position pairs across two ranges as four signed prefix terms. Two prefix pointers
// persist between queries and move one position per step toward each term's bounds;
// every step reads the element memory, then the paired histogram memory, and writes
// the updated entry back, through the pick, element and histogram states. The number
// of pointer steps in a query is set by how far the bounds lie from those of the
// previous query. After reset the histogram memory is cleared one entry per cycle,
// and no transaction is accepted until the clearing is done. A new transaction is
// accepted while the previous result still waits in the output register.
module range_pair_equal_count_core #(
    parameter int MAX_LENGTH  = rpec_pkg::MAX_LENGTH_DEFAULT,
    parameter int VALUE_COUNT = rpec_pkg::VALUE_COUNT_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rpec_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rpec_pkg::out_item_t out_data
);

`include "range_pair_equal_count_core_defines.svh"

    localparam int ELEM_AW = $clog2(MAX_LENGTH);
    localparam int HIST_AW = $clog2(VALUE_COUNT);
    localparam int PTR_W   = $clog2(MAX_LENGTH + 1);
    localparam int CNT_W   = PTR_W;
    localparam int HIST_DW = 2 * CNT_W;
    localparam int SUM_W   = rpec_pkg::SUM_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PICK,
        S_ELEM,
        S_HIST,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic                 started_reg, started_next;
    logic [PTR_W-1:0]     fp_reg, fp_next;
    logic [PTR_W-1:0]     sp_reg, sp_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [SUM_W-1:0]     acc_reg, acc_next;
    logic [1:0]           term_reg, term_next;
    rpec_pkg::step_kind_t kind_reg, kind_next;
    logic [HIST_AW-1:0]   val_reg, val_next;
    logic [PTR_W-1:0]     r1_reg, r1_next;
    logic [PTR_W-1:0]     l1_reg, l1_next;
    logic [PTR_W-1:0]     r2_reg, r2_next;
    logic [PTR_W-1:0]     l2_reg, l2_next;
    rpec_pkg::out_item_t  res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    rpec_pkg::out_item_t  out_data_reg, out_data_next;
    logic [HIST_AW-1:0]   clr_addr_reg, clr_addr_next;

    logic                 accept;
    logic                 load_ok;
    logic                 elem_we;
    logic [ELEM_AW-1:0]   elem_waddr;
    logic                 elem_re;
    logic [ELEM_AW-1:0]   elem_raddr;
    logic [rpec_pkg::VAL_W-1:0] elem_rdata;

    logic                 hist_we;
    logic [HIST_AW-1:0]   hist_waddr;
    logic [HIST_DW-1:0]   hist_wdata;
    logic                 hist_re;
    logic [HIST_AW-1:0]   hist_raddr;
    logic [HIST_DW-1:0]   hist_rdata;

    logic [PTR_W-1:0]     tx;
    logic [PTR_W-1:0]     ty;
    logic                 term_neg;
    logic [SUM_W-1:0]     acc_term;
    logic [PTR_W-1:0]     sel_ptr;
    logic [PTR_W-1:0]     rd_pos;
    rpec_pkg::step_kind_t pick_kind;
    logic                 pick_step;

    logic [CNT_W-1:0]     first_count_new;
    logic [CNT_W-1:0]     second_count_new;
    logic [SUM_W-1:0]     step_sum;

    function automatic logic [PTR_W-1:0] clamp_bound(input logic [31:0] b);
        logic [PTR_W-1:0] r;
        if (b > 32'(MAX_LENGTH))
        begin
            r = PTR_W'(MAX_LENGTH);
        end
        else
        begin
            r = PTR_W'(b);
        end
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] clamp_left(input logic [rpec_pkg::POS_W-1:0] l);
        logic [PTR_W-1:0] r;
        if (l == '0)
        begin
            r = '0;
        end
        else
        begin
            r = clamp_bound(32'(l) - 32'd1);
        end
        return r;
    endfunction

    rpec_ram #(
        .DEPTH (MAX_LENGTH),
        .AW    (ELEM_AW),
        .DW    (rpec_pkg::VAL_W)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (in_data.element_value),
        .re    (elem_re),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    rpec_ram #(
        .DEPTH (VALUE_COUNT),
        .AW    (HIST_AW),
        .DW    (HIST_DW)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    rpec_step #(
        .CNT_W (CNT_W)
    ) u_step (
        .kind             (kind_reg),
        .first_count      (hist_rdata[CNT_W-1:0]),
        .second_count     (hist_rdata[HIST_DW-1:CNT_W]),
        .sum              (sum_reg),
        .first_count_new  (first_count_new),
        .second_count_new (second_count_new),
        .sum_new          (step_sum)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign load_ok = !started_reg && (in_data.position != '0)
                     && (32'(in_data.position) <= 32'(MAX_LENGTH))
                     && (32'(in_data.element_value) < 32'(VALUE_COUNT));
    assign elem_we    = accept && (in_data.op == rpec_pkg::OP_LOAD) && load_ok;
    assign elem_waddr = ELEM_AW'(in_data.position - rpec_pkg::POS_W'(1));

    assign tx       = term_reg[0] ? l1_reg : r1_reg;
    assign ty       = term_reg[1] ? l2_reg : r2_reg;
    assign term_neg = term_reg[0] ^ term_reg[1];
    assign acc_term = term_neg ? (acc_reg - sum_reg) : (acc_reg + sum_reg);

    always_comb
    begin
        pick_step = 1'b1;
        pick_kind = rpec_pkg::STEP_FIRST_UP;
        if (fp_reg < tx)
        begin
            pick_kind = rpec_pkg::STEP_FIRST_UP;
        end
        else if (sp_reg < ty)
        begin
            pick_kind = rpec_pkg::STEP_SECOND_UP;
        end
        else if (fp_reg > tx)
        begin
            pick_kind = rpec_pkg::STEP_FIRST_DOWN;
        end
        else if (sp_reg > ty)
        begin
            pick_kind = rpec_pkg::STEP_SECOND_DOWN;
        end
        else
        begin
            pick_step = 1'b0;
        end
    end

    assign sel_ptr = ((pick_kind == rpec_pkg::STEP_FIRST_UP)
                      || (pick_kind == rpec_pkg::STEP_FIRST_DOWN)) ? fp_reg : sp_reg;
    assign rd_pos  = ((pick_kind == rpec_pkg::STEP_FIRST_UP)
                      || (pick_kind == rpec_pkg::STEP_SECOND_UP))
                     ? sel_ptr : (sel_ptr - PTR_W'(1));
    assign elem_raddr = ELEM_AW'(rd_pos);
    assign elem_re    = (state_reg == S_PICK) && pick_step;

    assign hist_raddr = HIST_AW'(elem_rdata);
    assign hist_re    = (state_reg == S_ELEM);

    always_comb
    begin
        hist_we    = 1'b0;
        hist_waddr = val_reg;
        hist_wdata = {second_count_new, first_count_new};
        if (state_reg == S_CLEAR)
        begin
            hist_we    = 1'b1;
            hist_waddr = clr_addr_reg;
            hist_wdata = '0;
        end
        else if (state_reg == S_HIST)
        begin
            hist_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        fp_next        = fp_reg;
        sp_next        = sp_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        term_next      = term_reg;
        kind_next      = kind_reg;
        val_next       = val_reg;
        r1_next        = r1_reg;
        l1_next        = l1_reg;
        r2_next        = r2_reg;
        l2_next        = l2_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        clr_addr_next  = clr_addr_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == HIST_AW'(VALUE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + HIST_AW'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.op == rpec_pkg::OP_QUERY)
                    begin
                        started_next = 1'b1;
                        r1_next      = clamp_bound(32'(in_data.first_right));
                        l1_next      = clamp_left(in_data.first_left);
                        r2_next      = clamp_bound(32'(in_data.second_right));
                        l2_next      = clamp_left(in_data.second_left);
                        term_next    = 2'd0;
                        acc_next     = '0;
                        state_next   = S_PICK;
                    end
                    else
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                end
            end
            S_PICK:
            begin
                if (pick_step)
                begin
                    kind_next  = pick_kind;
                    state_next = S_ELEM;
                end
                else
                begin
                    acc_next = acc_term;
                    if (term_reg == 2'd3)
                    begin
                        res_next.pair_count = acc_term;
                        res_next.is_answer  = 1'b1;
                        state_next          = S_DONE;
                    end
                    else
                    begin
                        term_next = term_reg + 2'd1;
                    end
                end
            end
            S_ELEM:
            begin
                val_next   = hist_raddr;
                state_next = S_HIST;
            end
            S_HIST:
            begin
                sum_next = step_sum;
                case (kind_reg)
                    rpec_pkg::STEP_FIRST_UP:    fp_next = fp_reg + PTR_W'(1);
                    rpec_pkg::STEP_SECOND_UP:   sp_next = sp_reg + PTR_W'(1);
                    rpec_pkg::STEP_FIRST_DOWN:  fp_next = fp_reg - PTR_W'(1);
                    rpec_pkg::STEP_SECOND_DOWN: sp_next = sp_reg - PTR_W'(1);
                    default:                    fp_next = fp_reg;
                endcase
                state_next = S_PICK;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            started_reg   <= 1'b0;
            fp_reg        <= '0;
            sp_reg        <= '0;
            sum_reg       <= '0;
            acc_reg       <= '0;
            term_reg      <= 2'd0;
            kind_reg      <= rpec_pkg::STEP_FIRST_UP;
            val_reg       <= '0;
            r1_reg        <= '0;
            l1_reg        <= '0;
            r2_reg        <= '0;
            l2_reg        <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            fp_reg        <= fp_next;
            sp_reg        <= sp_next;
            sum_reg       <= sum_next;
            acc_reg       <= acc_next;
            term_reg      <= term_next;
            kind_reg      <= kind_next;
            val_reg       <= val_next;
            r1_reg        <= r1_next;
            l1_reg        <= l1_next;
            r2_reg        <= r2_next;
            l2_reg        <= l2_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            clr_addr_reg  <= clr_addr_next;
        end
    end

    `RPEC_ASSERT_NOW(a_no_accept_while_clearing, state_reg == S_CLEAR, !in_ready,
        "transaction accepted during histogram clearing")
    `RPEC_ASSERT_NOW(a_no_late_load, elem_we, !started_reg,
        "element memory written after the first query")
    `RPEC_ASSERT_NOW(a_pointers_in_range, 1'b1,
        (32'(fp_reg) <= 32'(MAX_LENGTH)) && (32'(sp_reg) <= 32'(MAX_LENGTH)),
        "prefix pointer beyond array length")
    `RPEC_ASSERT_NEXT(a_query_sets_started,
        accept && (in_data.op == rpec_pkg::OP_QUERY), started_reg,
        "query accepted without marking queries started")
    `RPEC_ASSERT_NOW(a_hist_write_source, hist_we,
        (state_reg == S_CLEAR) || (state_reg == S_HIST),
        "histogram written outside clearing or update step")

endmodule

// ----- verif/tb_range_pair_equal_count_core.sv -----
// Testbench for the range pair equal count core with its own pair count prediction.
`timescale 1ns / 100ps

module tb_range_pair_equal_count_core;

    localparam int unsigned ARRAY_LEN      = rpec_pkg::MAX_LENGTH_DEFAULT;
    localparam int unsigned VALUE_RANGE    = rpec_pkg::VALUE_COUNT_DEFAULT;
    localparam int unsigned WINDOW         = 32;
    localparam int unsigned WIDE_WINDOW    = 300;
    localparam int unsigned LOADED_LEN     = WIDE_WINDOW + 20;
    localparam int unsigned QUERY_TARGET   = 700;
    localparam int unsigned DRAIN_CYCLES   = 64;
    localparam int unsigned TIMEOUT_CYCLES = 8_000_000;
    localparam int unsigned MAX_REPORTS    = 10;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    rpec_pkg::in_item_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    rpec_pkg::out_item_t out_data;

    rpec_pkg::in_item_t  item_backlog[$];
    rpec_pkg::out_item_t awaited_results[$];

    int unsigned accepted_count = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned phase_edge_a   = '1;
    int unsigned phase_edge_b   = '1;

    logic [rpec_pkg::VAL_W-1:0] element_mem [ARRAY_LEN];
    int unsigned                hist_first  [VALUE_RANGE];
    int unsigned                hist_second [VALUE_RANGE];
    int unsigned                ptr_first   = 0;
    int unsigned                ptr_second  = 0;
    logic [rpec_pkg::SUM_W-1:0] pair_sum    = '0;
    bit                         queries_seen = 1'b0;

    range_pair_equal_count_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned stored_value(int unsigned pos);
        if (pos == 0 || pos > ARRAY_LEN)
        begin
            return 0;
        end
        return element_mem[pos - 1];
    endfunction

    function automatic int unsigned upper_bound(logic [rpec_pkg::POS_W-1:0] r);
        return (r > ARRAY_LEN) ? ARRAY_LEN : 32'(r);
    endfunction

    function automatic int unsigned lower_bound(logic [rpec_pkg::POS_W-1:0] l);
        return (l == 0) ? 0 : upper_bound(l - 1'b1);
    endfunction

    // Moves both prefix pointers to (x, y) and returns the equal pair count of those prefixes.
    function automatic logic [rpec_pkg::SUM_W-1:0] walk_prefixes(int unsigned x,
                                                                 int unsigned y);
        int unsigned v;
        while (ptr_first < x)
        begin
            ptr_first++;
            v = stored_value(ptr_first);
            pair_sum += rpec_pkg::SUM_W'(hist_second[v]);
            hist_first[v]++;
        end
        while (ptr_second < y)
        begin
            ptr_second++;
            v = stored_value(ptr_second);
            pair_sum += rpec_pkg::SUM_W'(hist_first[v]);
            hist_second[v]++;
        end
        while (ptr_first > x)
        begin
            v = stored_value(ptr_first);
            if (hist_first[v] != 0)
            begin
                hist_first[v]--;
            end
            pair_sum -= rpec_pkg::SUM_W'(hist_second[v]);
            ptr_first--;
        end
        while (ptr_second > y)
        begin
            v = stored_value(ptr_second);
            if (hist_second[v] != 0)
            begin
                hist_second[v]--;
            end
            pair_sum -= rpec_pkg::SUM_W'(hist_first[v]);
            ptr_second--;
        end
        return pair_sum;
    endfunction

    function automatic rpec_pkg::out_item_t predict_answer(rpec_pkg::in_item_t item);
        rpec_pkg::out_item_t        res;
        int unsigned                r1, l1, r2, l2;
        logic [rpec_pkg::SUM_W-1:0] acc;
        res = '0;
        if (item.op == rpec_pkg::OP_LOAD)
        begin
            if (!queries_seen && item.position >= 1 && item.position <= ARRAY_LEN
                && item.element_value < VALUE_RANGE)
            begin
                element_mem[item.position - 1] = item.element_value;
            end
            return res;
        end
        queries_seen = 1'b1;
        r1 = upper_bound(item.first_right);
        l1 = lower_bound(item.first_left);
        r2 = upper_bound(item.second_right);
        l2 = lower_bound(item.second_left);
        acc = walk_prefixes(r1, r2);
        acc -= walk_prefixes(l1, r2);
        acc -= walk_prefixes(r1, l2);
        acc += walk_prefixes(l1, l2);
        res.pair_count = acc;
        res.is_answer  = 1'b1;
        return res;
    endfunction

    function automatic int unsigned send_idle_pct(int unsigned count);
        if (count < phase_edge_a)
        begin
            return 31;
        end
        if (count < phase_edge_b)
        begin
            return 63;
        end
        return 0;
    endfunction

    function automatic int unsigned take_idle_pct(int unsigned count);
        if (count < phase_edge_a)
        begin
            return 63;
        end
        if (count < phase_edge_b)
        begin
            return 31;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                awaited_results.push_back(predict_answer(in_data));
                accepted_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (item_backlog.size() != 0
                    && $urandom_range(99) >= send_idle_pct(accepted_count))
                begin
                    in_valid <= 1'b1;
                    in_data  <= item_backlog.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        rpec_pkg::out_item_t want;
        if (rst_n)
        begin
            out_ready <= ($urandom_range(99) >= take_idle_pct(results_seen));
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                    begin
                        $display("unexpected transaction: pair_count %0d is_answer %0b",
                                 out_data.pair_count, out_data.is_answer);
                    end
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_data.pair_count !== want.pair_count
                        || out_data.is_answer !== want.is_answer)
                    begin
                        if (mismatch_count < MAX_REPORTS)
                        begin
                            $display("mismatch on transaction %0d: pair_count exp %0d got %0d, %s",
                                     results_seen, want.pair_count, out_data.pair_count,
                                     $sformatf("is_answer exp %0b got %0b",
                                               want.is_answer, out_data.is_answer));
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic push_load(int unsigned pos, int unsigned value);
        rpec_pkg::in_item_t item;
        item.op            = rpec_pkg::OP_LOAD;
        item.position      = rpec_pkg::POS_W'(pos);
        item.element_value = rpec_pkg::VAL_W'(value);
        item.first_left    = rpec_pkg::POS_W'($urandom);
        item.first_right   = rpec_pkg::POS_W'($urandom);
        item.second_left   = rpec_pkg::POS_W'($urandom);
        item.second_right  = rpec_pkg::POS_W'($urandom);
        item_backlog.push_back(item);
    endtask

    task automatic push_query(int unsigned l1, int unsigned r1, int unsigned l2,
                              int unsigned r2);
        rpec_pkg::in_item_t item;
        item.op            = rpec_pkg::OP_QUERY;
        item.position      = rpec_pkg::POS_W'($urandom);
        item.element_value = rpec_pkg::VAL_W'($urandom);
        item.first_left    = rpec_pkg::POS_W'(l1);
        item.first_right   = rpec_pkg::POS_W'(r1);
        item.second_left   = rpec_pkg::POS_W'(l2);
        item.second_right  = rpec_pkg::POS_W'(r2);
        item_backlog.push_back(item);
    endtask

    task automatic pick_range(int unsigned span, bit broken, output int unsigned l,
                              output int unsigned r);
        int unsigned a, b;
        if (broken)
        begin
            l = $urandom_range(span + 1, 0);
            r = $urandom_range(span, 0);
        end
        else
        begin
            a = $urandom_range(span, 0);
            b = $urandom_range(span, 0);
            l = ((a < b) ? a : b) + 1;
            r = (a < b) ? b : a;
        end
    endtask

    initial
    begin
        int unsigned total_items;
        int unsigned queries_made;
        int unsigned roll;
        int unsigned l1, r1, l2, r2;

        // Queries stay inside the loaded prefix of the array.
        for (int unsigned pos = 1; pos <= LOADED_LEN; pos++)
        begin
            if (pos <= WIDE_WINDOW)
            begin
                roll = $urandom_range(4, 0);
                push_load(pos, (roll == 4) ? 65535 : roll);
            end
            else
            begin
                push_load(pos, ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0)
                                                           : $urandom_range(7, 0));
            end
        end
        push_load(1, 65535);
        push_load(ARRAY_LEN, 65535);
        push_load(2, 0);
        push_load(0, 1234);
        push_load(ARRAY_LEN + 1, 7);
        push_load(131071, 65535);

        push_query(1, 1, 1, 1);
        push_query(1, WINDOW, 1, WINDOW);
        push_query(1, 0, 1, 0);
        push_query(5, 4, 1, WINDOW);
        push_query(0, 10, 3, 7);
        push_query(3, 7, 0, 0);
        push_query(20, 3, 1, WINDOW);
        push_query(1, WINDOW, WINDOW, 2);
        push_query(10, 20, 1, 9);
        push_load(3, 9);
        push_query(3, 3, 1, WINDOW);
        push_load(0, 65535);
        push_load(131071, 0);
        push_query(2, 2, 1, 1);

        queries_made = 0;
        while (queries_made < QUERY_TARGET)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 8)
            begin
                push_load($urandom_range(131071, 0), $urandom_range(65535, 0));
            end
            else
            begin
                pick_range(($urandom_range(49, 0) == 0) ? WIDE_WINDOW : WINDOW, roll >= 90,
                           l1, r1);
                pick_range(($urandom_range(49, 0) == 0) ? WIDE_WINDOW : WINDOW, roll >= 90,
                           l2, r2);
                push_query(l1, r1, l2, r2);
                queries_made++;
            end
        end
        total_items = item_backlog.size();
        phase_edge_a = total_items / 3;
        phase_edge_b = 2 * phase_edge_a;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_count < total_items || awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_results.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 2);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
